// ===== hw/rtl/emps_pkg.sv =====
// ----------------------------------------------------------------------------
// emps_pkg
// Shared types and codes for the encoder motor position stop core.
// ----------------------------------------------------------------------------
package emps_pkg;

  // transaction kinds
  typedef enum logic [2:0] {
    KIND_EDGE  = 3'd0,
    KIND_MOVE  = 3'd1,
    KIND_ROT   = 3'd2,
    KIND_STOP  = 3'd3,
    KIND_COAST = 3'd4,
    KIND_CLEAR = 3'd5
  } kind_t;

  // direction codes
  localparam logic [1:0] DIR_FWD = 2'd0;
  localparam logic [1:0] DIR_BWD = 2'd1;

  // halt mode codes
  localparam logic [1:0] HALT_BRAKE = 2'd0;
  localparam logic [1:0] HALT_COAST = 2'd1;

  // bridge patterns, bit 0 drives drive_a and bit 1 drives drive_b
  localparam logic [1:0] BRIDGE_FWD   = 2'b01;
  localparam logic [1:0] BRIDGE_BWD   = 2'b10;
  localparam logic [1:0] BRIDGE_BRAKE = 2'b11;

  localparam logic [7:0] FULL_DUTY = 8'd255;
  localparam logic [7:0] ZERO_DUTY = 8'd0;

  // one input transaction
  typedef struct packed {
    logic [2:0]  kind;
    logic        chan_a;
    logic        chan_b;
    logic [1:0]  direction;
    logic [7:0]  speed;
    logic [31:0] rotation;
    logic [1:0]  halt_mode;
  } cmd_t;

  // one result transaction
  typedef struct packed {
    logic [7:0]         pwm_duty;
    logic               drive_a;
    logic               drive_b;
    logic signed [31:0] count;
    logic               running;
  } res_t;

endpackage

// ===== hw/rtl/emps_in_stage.sv =====
// ----------------------------------------------------------------------------
// emps_in_stage
// Input register: holds one command transaction until the update logic takes it.
// ----------------------------------------------------------------------------
module emps_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  emps_pkg::cmd_t in_cmd,
  input  logic           take,
  output logic           cmd_valid,
  output emps_pkg::cmd_t cmd
);

  logic           valid_r;
  logic           valid_nxt;
  emps_pkg::cmd_t cmd_r;

  // room when empty or when the held transaction leaves this cycle
  assign in_ready  = !valid_r || take;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= in_cmd;
    end
  end

  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

  // a held transaction stays until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !take |=> valid_r && $stable(cmd_r))
    else $error("input stage dropped a held transaction");

  // never take from an empty stage
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> valid_r)
    else $error("take with no transaction held");

  // a transaction arriving while the stage is full must see the old one leave
  a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && valid_r |-> take)
    else $error("overwrite of a held transaction");

endmodule

// ===== hw/rtl/emps_ctrl.sv =====
// ----------------------------------------------------------------------------
// emps_ctrl
// Motor state: position counter, target compare and drive state update.
// ----------------------------------------------------------------------------
module emps_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           take,
  input  emps_pkg::cmd_t cmd,
  output emps_pkg::res_t res
);

  logic [31:0] count_r,   count_nxt;
  logic [31:0] target_r,  target_nxt;
  logic        running_r, running_nxt;
  logic        armed_r,   armed_nxt;
  logic        fwd_r,     fwd_nxt;
  logic        brake_r,   brake_nxt;
  logic [7:0]  duty_r,    duty_nxt;
  logic [1:0]  bridge_r,  bridge_nxt;

  logic [31:0] edge_count;
  logic        reached;

  // counter step and target compare on the stepped value
  assign edge_count = (cmd.chan_a == cmd.chan_b) ? count_r + 32'd1 : count_r - 32'd1;
  assign reached    = fwd_r ? ($signed(edge_count) <= $signed(target_r))
                            : ($signed(target_r) <= $signed(edge_count));

  // next state
  always_comb begin
    count_nxt   = count_r;
    target_nxt  = target_r;
    running_nxt = running_r;
    armed_nxt   = armed_r;
    fwd_nxt     = fwd_r;
    brake_nxt   = brake_r;
    duty_nxt    = duty_r;
    bridge_nxt  = bridge_r;
    unique case (cmd.kind)
      emps_pkg::KIND_EDGE: begin
        count_nxt = edge_count;
        if (armed_r && running_r && reached) begin
          running_nxt = 1'b0;
          if (brake_r) begin
            duty_nxt   = emps_pkg::FULL_DUTY;
            bridge_nxt = emps_pkg::BRIDGE_BRAKE;
          end else begin
            duty_nxt = emps_pkg::ZERO_DUTY;
          end
        end
      end
      emps_pkg::KIND_MOVE: begin
        running_nxt = 1'b1;
        armed_nxt   = 1'b0;
        duty_nxt    = cmd.speed;
        if (cmd.direction == emps_pkg::DIR_FWD) begin
          bridge_nxt = emps_pkg::BRIDGE_FWD;
        end else if (cmd.direction == emps_pkg::DIR_BWD) begin
          bridge_nxt = emps_pkg::BRIDGE_BWD;
        end
      end
      emps_pkg::KIND_ROT: begin
        running_nxt = 1'b1;
        armed_nxt   = 1'b1;
        duty_nxt    = cmd.speed;
        if (cmd.halt_mode == emps_pkg::HALT_BRAKE) begin
          brake_nxt = 1'b1;
        end else if (cmd.halt_mode == emps_pkg::HALT_COAST) begin
          brake_nxt = 1'b0;
        end
        if (cmd.direction == emps_pkg::DIR_FWD) begin
          fwd_nxt    = 1'b1;
          target_nxt = count_r - cmd.rotation;
          bridge_nxt = emps_pkg::BRIDGE_FWD;
        end else if (cmd.direction == emps_pkg::DIR_BWD) begin
          fwd_nxt    = 1'b0;
          target_nxt = count_r + cmd.rotation;
          bridge_nxt = emps_pkg::BRIDGE_BWD;
        end
      end
      emps_pkg::KIND_STOP: begin
        running_nxt = 1'b0;
        duty_nxt    = emps_pkg::FULL_DUTY;
        bridge_nxt  = emps_pkg::BRIDGE_BRAKE;
      end
      emps_pkg::KIND_COAST: begin
        running_nxt = 1'b0;
        duty_nxt    = emps_pkg::ZERO_DUTY;
      end
      emps_pkg::KIND_CLEAR: begin
        count_nxt = 32'd0;
      end
      default: begin
      end
    endcase
  end

  // state registers, updated as each transaction passes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= 32'd0;
      target_r  <= 32'd0;
      running_r <= 1'b0;
      armed_r   <= 1'b0;
      fwd_r     <= 1'b0;
      brake_r   <= 1'b0;
      duty_r    <= 8'd0;
      bridge_r  <= 2'd0;
    end else if (take) begin
      count_r   <= count_nxt;
      target_r  <= target_nxt;
      running_r <= running_nxt;
      armed_r   <= armed_nxt;
      fwd_r     <= fwd_nxt;
      brake_r   <= brake_nxt;
      duty_r    <= duty_nxt;
      bridge_r  <= bridge_nxt;
    end
  end

  // result shows the state after the transaction
  assign res.pwm_duty = duty_nxt;
  assign res.drive_a  = bridge_nxt[0];
  assign res.drive_b  = bridge_nxt[1];
  assign res.count    = $signed(count_nxt);
  assign res.running  = running_nxt;

  // stop brakes hard
  a_stop: assert property (@(posedge clk) disable iff (!rst_n)
    take && cmd.kind == emps_pkg::KIND_STOP |=>
      !running_r && duty_r == emps_pkg::FULL_DUTY && bridge_r == emps_pkg::BRIDGE_BRAKE)
    else $error("stop did not brake");

  // count clear
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    take && cmd.kind == emps_pkg::KIND_CLEAR |=> count_r == 32'd0)
    else $error("count clear failed");

  // an edge never starts the motor
  a_edge_no_start: assert property (@(posedge clk) disable iff (!rst_n)
    take && cmd.kind == emps_pkg::KIND_EDGE && !running_r |=> !running_r)
    else $error("encoder edge started the motor");

  // an idle cycle leaves the state alone
  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !take |=> $stable(count_r) && $stable(running_r) && $stable(duty_r))
    else $error("state changed without a transaction");

endmodule

// ===== hw/rtl/emps_out_stage.sv =====
// ----------------------------------------------------------------------------
// emps_out_stage
// Result register: holds one result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module emps_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  emps_pkg::res_t res,
  output logic           take,
  output logic           out_valid,
  input  logic           out_ready,
  output emps_pkg::res_t out_res
);

  logic           valid_r;
  logic           valid_nxt;
  emps_pkg::res_t res_r;

  // move a transaction forward when the result slot is free or draining
  assign take      = cmd_valid && (!valid_r || out_ready);
  assign valid_nxt = take || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

  // a waiting result is not overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !out_ready |-> !take)
    else $error("result overwritten before delivery");

  // a taken transaction shows up as a result next cycle
  a_take_shows: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> valid_r && res_r == $past(res))
    else $error("taken transaction not presented");

  // a result leaves only through the handshake
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && out_ready && !take |=> !valid_r)
    else $error("delivered result repeated");

endmodule

// ===== hw/rtl/encoder_motor_position_stop_core.sv =====
// An accepted command passes the input register, then the result register.
// Throughput: one transaction per cycle unless the result side stalls; the
// counter step and target compare sit between the input and result registers.
// Backpressure on the result side stalls the input register, one item deep each.
// Reset (synchronous, rst_n low): position, target, flags, duty and bridge clear.
// ----------------------------------------------------------------------------
// encoder_motor_position_stop_core
// Quadrature position counter with move commands and automatic target stop.
// ----------------------------------------------------------------------------
module encoder_motor_position_stop_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_kind,
  input  logic               in_chan_a,
  input  logic               in_chan_b,
  input  logic [1:0]         in_direction,
  input  logic [7:0]         in_speed,
  input  logic [31:0]        in_rotation,
  input  logic [1:0]         in_halt_mode,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_pwm_duty,
  output logic               out_drive_a,
  output logic               out_drive_b,
  output logic signed [31:0] out_count,
  output logic               out_running
);

  emps_pkg::cmd_t in_cmd;
  emps_pkg::cmd_t cmd;
  emps_pkg::res_t res;
  emps_pkg::res_t out_res;
  logic           cmd_valid;
  logic           take;

  // gather the input ports
  assign in_cmd.kind      = in_kind;
  assign in_cmd.chan_a    = in_chan_a;
  assign in_cmd.chan_b    = in_chan_b;
  assign in_cmd.direction = in_direction;
  assign in_cmd.speed     = in_speed;
  assign in_cmd.rotation  = in_rotation;
  assign in_cmd.halt_mode = in_halt_mode;

  emps_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .take      (take),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  emps_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .cmd   (cmd),
    .res   (res)
  );

  emps_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .res       (res),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  // spread the result onto ports
  assign out_pwm_duty = out_res.pwm_duty;
  assign out_drive_a  = out_res.drive_a;
  assign out_drive_b  = out_res.drive_b;
  assign out_count    = out_res.count;
  assign out_running  = out_res.running;

endmodule

// ===== tb/sv/motor_drive_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_drive_checker
// Watches both channels of the position stop core. It keeps its own copy of
// position, halt target, flags, duty and bridge state, predicts the drive
// state for every accepted command or encoder transaction, and compares each
// accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module motor_drive_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         in_kind,
  input  logic               in_chan_a,
  input  logic               in_chan_b,
  input  logic [1:0]         in_direction,
  input  logic [7:0]         in_speed,
  input  logic [31:0]        in_rotation,
  input  logic [1:0]         in_halt_mode,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [7:0]         out_pwm_duty,
  input  logic               out_drive_a,
  input  logic               out_drive_b,
  input  logic signed [31:0] out_count,
  input  logic               out_running,
  output int unsigned        mismatch_count,
  output int unsigned        results_pending
);

  localparam int unsigned REPORT_LIMIT = 10;

  // shadow of the motor drive state
  logic [31:0] position;
  logic [31:0] halt_target;
  logic        motor_running;
  logic        halt_armed;
  logic        heading_fwd;
  logic        brake_on_halt;
  logic [7:0]  duty;
  logic [1:0]  bridge;

  emps_pkg::res_t drive_state_q[$];
  int unsigned    errors = 0;

  // drive state after one transaction; updates the shadow state
  function automatic emps_pkg::res_t next_drive_state(input emps_pkg::cmd_t c);
    emps_pkg::res_t r;
    logic reached;
    reached = 1'b0;
    case (c.kind)
      emps_pkg::KIND_EDGE: begin
        position = (c.chan_a == c.chan_b) ? position + 32'd1 : position - 32'd1;
        if (halt_armed && motor_running) begin
          reached = heading_fwd ? ($signed(position) <= $signed(halt_target))
                                : ($signed(halt_target) <= $signed(position));
          if (reached) begin
            motor_running = 1'b0;
            if (brake_on_halt) begin
              duty   = emps_pkg::FULL_DUTY;
              bridge = emps_pkg::BRIDGE_BRAKE;
            end else begin
              duty = emps_pkg::ZERO_DUTY;
            end
          end
        end
      end
      emps_pkg::KIND_MOVE: begin
        motor_running = 1'b1;
        halt_armed    = 1'b0;
        duty          = c.speed;
        if (c.direction == emps_pkg::DIR_FWD) bridge = emps_pkg::BRIDGE_FWD;
        else if (c.direction == emps_pkg::DIR_BWD) bridge = emps_pkg::BRIDGE_BWD;
      end
      emps_pkg::KIND_ROT: begin
        motor_running = 1'b1;
        halt_armed    = 1'b1;
        if (c.halt_mode == emps_pkg::HALT_BRAKE) brake_on_halt = 1'b1;
        else if (c.halt_mode == emps_pkg::HALT_COAST) brake_on_halt = 1'b0;
        duty = c.speed;
        if (c.direction == emps_pkg::DIR_FWD) begin
          heading_fwd = 1'b1;
          halt_target = position - c.rotation;
          bridge      = emps_pkg::BRIDGE_FWD;
        end else if (c.direction == emps_pkg::DIR_BWD) begin
          heading_fwd = 1'b0;
          halt_target = position + c.rotation;
          bridge      = emps_pkg::BRIDGE_BWD;
        end
      end
      emps_pkg::KIND_STOP: begin
        motor_running = 1'b0;
        duty          = emps_pkg::FULL_DUTY;
        bridge        = emps_pkg::BRIDGE_BRAKE;
      end
      emps_pkg::KIND_COAST: begin
        motor_running = 1'b0;
        duty          = emps_pkg::ZERO_DUTY;
      end
      emps_pkg::KIND_CLEAR: begin
        position = 32'd0;
      end
      default: begin
      end
    endcase
    r.pwm_duty = duty;
    r.drive_a  = bridge[0];
    r.drive_b  = bridge[1];
    r.count    = position;
    r.running  = motor_running;
    return r;
  endfunction

  // predict on input transactions, compare on result transactions
  always @(posedge clk) begin
    emps_pkg::cmd_t c;
    emps_pkg::res_t want;
    if (!rst_n) begin
      position      = 32'd0;
      halt_target   = 32'd0;
      motor_running = 1'b0;
      halt_armed    = 1'b0;
      heading_fwd   = 1'b0;
      brake_on_halt = 1'b0;
      duty          = emps_pkg::ZERO_DUTY;
      bridge        = 2'b00;
      drive_state_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        c.kind      = in_kind;
        c.chan_a    = in_chan_a;
        c.chan_b    = in_chan_b;
        c.direction = in_direction;
        c.speed     = in_speed;
        c.rotation  = in_rotation;
        c.halt_mode = in_halt_mode;
        drive_state_q.push_back(next_drive_state(c));
      end
      if (out_valid && out_ready) begin
        if (drive_state_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("[%0t] unexpected result: duty=%0d a=%0b b=%0b count=%0d run=%0b",
                     $realtime, out_pwm_duty, out_drive_a, out_drive_b, out_count,
                     out_running);
        end else begin
          want = drive_state_q.pop_front();
          if (out_pwm_duty !== want.pwm_duty || out_drive_a !== want.drive_a ||
              out_drive_b !== want.drive_b || out_count !== want.count ||
              out_running !== want.running) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $display({"[%0t] result mismatch: expected duty=%0d a=%0b b=%0b count=%0d",
                        " run=%0b, got duty=%0d a=%0b b=%0b count=%0d run=%0b"},
                       $realtime, want.pwm_duty, want.drive_a, want.drive_b,
                       want.count, want.running, out_pwm_duty, out_drive_a,
                       out_drive_b, out_count, out_running);
          end
        end
      end
    end
    mismatch_count  <= errors;
    results_pending <= unsigned'(drive_state_q.size());
  end

endmodule

// ===== tb/sv/tb_encoder_motor_position_stop_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_encoder_motor_position_stop_core
// Drives encoder edges and motor commands into the position stop core: a
// directed opening over the field extremes and halt corner cases, then
// positioning moves followed by edge runs toward and away from the target,
// mixed with stop, coast, count clear and unknown codes, under several
// sender and receiver idling mixes and one long result-side hold-off.
// ----------------------------------------------------------------------------
module tb_encoder_motor_position_stop_core;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam logic [2:0]  KIND_UNUSED_6  = 3'd6;
  localparam logic [2:0]  KIND_UNUSED_7  = 3'd7;
  localparam logic [1:0]  DIR_OTHER_2    = 2'd2;
  localparam logic [1:0]  DIR_OTHER_3    = 2'd3;
  localparam logic [1:0]  HALT_KEEP_2    = 2'd2;
  localparam logic [1:0]  HALT_KEEP_3    = 2'd3;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         in_kind;
  logic               in_chan_a;
  logic               in_chan_b;
  logic [1:0]         in_direction;
  logic [7:0]         in_speed;
  logic [31:0]        in_rotation;
  logic [1:0]         in_halt_mode;
  logic               out_valid;
  logic               out_ready;
  logic [7:0]         out_pwm_duty;
  logic               out_drive_a;
  logic               out_drive_b;
  logic signed [31:0] out_count;
  logic               out_running;

  int unsigned mismatch_count;
  int unsigned results_pending;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned items_sent;
  bit          long_hold_req;

  encoder_motor_position_stop_core DUT (.*);

  motor_drive_checker u_checker (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // known input levels from time zero
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_kind        = emps_pkg::KIND_EDGE;
    in_chan_a      = 1'b0;
    in_chan_b      = 1'b0;
    in_direction   = emps_pkg::DIR_FWD;
    in_speed       = 8'd0;
    in_rotation    = 32'd0;
    in_halt_mode   = emps_pkg::HALT_BRAKE;
    out_ready      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    items_sent     = 0;
    long_hold_req  = 1'b0;
  end

  // result side: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("encoder_motor_position_stop_core regression: fail");
    $finish;
  end

  // offer one transaction and hold it until accepted
  task automatic send_item(input logic [2:0] kind, input logic ca, input logic cb,
                           input logic [1:0] dir, input logic [7:0] spd,
                           input logic [31:0] rot, input logic [1:0] hm);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_chan_a    <= ca;
    in_chan_b    <= cb;
    in_direction <= dir;
    in_speed     <= spd;
    in_rotation  <= rot;
    in_halt_mode <= hm;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // encoder edge with junk in the unused fields
  task automatic encoder_step(input bit step_down);
    logic ca;
    ca = 1'($urandom_range(1));
    send_item(emps_pkg::KIND_EDGE, ca, step_down ? ~ca : ca, 2'($urandom_range(3)),
              8'($urandom_range(255)), $urandom, 2'($urandom_range(3)));
  endtask

  // motor command with random tachometer levels
  task automatic motor_command(input logic [2:0] kind, input logic [1:0] dir,
                               input logic [7:0] spd, input logic [31:0] rot,
                               input logic [1:0] hm);
    send_item(kind, 1'($urandom_range(1)), 1'($urandom_range(1)), dir, spd, rot, hm);
  endtask

  // positioning moves with edge runs, mixed with other commands
  task automatic run_random_items(input int unsigned n);
    int unsigned start;
    int unsigned pick;
    int unsigned run_len;
    logic [1:0]  dir;
    logic [31:0] rot;
    bit          toward_down;
    start = items_sent;
    while (items_sent - start < n) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        dir = ($urandom_range(9) == 0) ? 2'($urandom_range(3, 2)) : 2'($urandom_range(1));
        rot = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(12));
        motor_command(emps_pkg::KIND_ROT, dir, 8'($urandom_range(255)), rot,
                      2'($urandom_range(3)));
        // forward halts as the count falls, backward as it rises
        toward_down = (dir == emps_pkg::DIR_FWD) ? 1'b1 :
                      (dir == emps_pkg::DIR_BWD) ? 1'b0 : 1'($urandom_range(1));
        run_len = $urandom_range(16, 1);
        repeat (run_len) encoder_step(($urandom_range(99) < 85) ? toward_down : ~toward_down);
      end else if (pick < 70) begin
        motor_command(emps_pkg::KIND_MOVE, 2'($urandom_range(3)), 8'($urandom_range(255)),
                      $urandom, 2'($urandom_range(3)));
        run_len = $urandom_range(6);
        repeat (run_len) encoder_step(1'($urandom_range(1)));
      end else if (pick < 78) begin
        motor_command(emps_pkg::KIND_STOP, 2'($urandom_range(3)), 8'($urandom_range(255)),
                      $urandom, 2'($urandom_range(3)));
      end else if (pick < 86) begin
        motor_command(emps_pkg::KIND_COAST, 2'($urandom_range(3)), 8'($urandom_range(255)),
                      $urandom, 2'($urandom_range(3)));
      end else if (pick < 93) begin
        motor_command(emps_pkg::KIND_CLEAR, 2'($urandom_range(3)), 8'($urandom_range(255)),
                      $urandom, 2'($urandom_range(3)));
      end else if (pick < 96) begin
        motor_command($urandom_range(1) ? KIND_UNUSED_6 : KIND_UNUSED_7,
                      2'($urandom_range(3)), 8'($urandom_range(255)), $urandom,
                      2'($urandom_range(3)));
      end else begin
        encoder_step(1'($urandom_range(1)));
      end
    end
  endtask

  // main sequence
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: edge directions, moves, halt corners, odd codes
    send_item(emps_pkg::KIND_EDGE, 1'b0, 1'b0, emps_pkg::DIR_FWD, 8'd0, 32'd0,
              emps_pkg::HALT_BRAKE);
    send_item(emps_pkg::KIND_EDGE, 1'b1, 1'b1, emps_pkg::DIR_BWD, 8'hFF, 32'hFFFF_FFFF,
              emps_pkg::HALT_COAST);
    send_item(emps_pkg::KIND_EDGE, 1'b0, 1'b1, DIR_OTHER_3, 8'd0, 32'd0, HALT_KEEP_3);
    send_item(emps_pkg::KIND_EDGE, 1'b1, 1'b0, DIR_OTHER_2, 8'hFF, 32'hFFFF_FFFF,
              HALT_KEEP_2);
    motor_command(emps_pkg::KIND_MOVE, emps_pkg::DIR_FWD, 8'hFF, 32'd0, emps_pkg::HALT_BRAKE);
    motor_command(emps_pkg::KIND_MOVE, emps_pkg::DIR_BWD, 8'd0, 32'hFFFF_FFFF,
                  emps_pkg::HALT_COAST);
    motor_command(emps_pkg::KIND_MOVE, DIR_OTHER_2, 8'h5A, 32'd7, HALT_KEEP_2);
    motor_command(emps_pkg::KIND_MOVE, DIR_OTHER_3, 8'hA5, 32'd9, HALT_KEEP_3);
    // zero rotation forward: rising edge passes by, falling edge brakes
    motor_command(emps_pkg::KIND_ROT, emps_pkg::DIR_FWD, 8'd128, 32'd0, emps_pkg::HALT_BRAKE);
    encoder_step(1'b0);
    encoder_step(1'b1);
    // armed but stopped: no action
    encoder_step(1'b1);
    // backward by two, coast on arrival
    motor_command(emps_pkg::KIND_ROT, emps_pkg::DIR_BWD, 8'd1, 32'd2, emps_pkg::HALT_COAST);
    encoder_step(1'b0);
    encoder_step(1'b0);
    // full-scale rotation keeps the stored halt mode
    motor_command(emps_pkg::KIND_ROT, emps_pkg::DIR_FWD, 8'd200, 32'hFFFF_FFFF, HALT_KEEP_2);
    encoder_step(1'b1);
    motor_command(emps_pkg::KIND_ROT, emps_pkg::DIR_BWD, 8'd77, 32'h8000_0000, HALT_KEEP_3);
    motor_command(emps_pkg::KIND_ROT, DIR_OTHER_2, 8'd33, 32'h7FFF_FFFF,
                  emps_pkg::HALT_BRAKE);
    encoder_step(1'b0);
    motor_command(emps_pkg::KIND_STOP, emps_pkg::DIR_FWD, 8'd10, 32'd5, emps_pkg::HALT_COAST);
    motor_command(emps_pkg::KIND_COAST, emps_pkg::DIR_BWD, 8'd20, 32'd6,
                  emps_pkg::HALT_BRAKE);
    motor_command(emps_pkg::KIND_CLEAR, DIR_OTHER_3, 8'd30, 32'd7, HALT_KEEP_2);
    motor_command(KIND_UNUSED_6, emps_pkg::DIR_FWD, 8'd40, 32'd8, emps_pkg::HALT_BRAKE);
    motor_command(KIND_UNUSED_7, emps_pkg::DIR_BWD, 8'd50, 32'd9, emps_pkg::HALT_COAST);
    motor_command(emps_pkg::KIND_ROT, emps_pkg::DIR_FWD, 8'd60, 32'h8000_0000,
                  emps_pkg::HALT_BRAKE);
    encoder_step(1'b1);

    // no idling, with one long result hold-off while items keep coming
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_items(300);
    long_hold_req = 1'b1;
    run_random_items(80);

    // sender mostly idle
    send_idle_pct  = 75;
    recv_stall_pct = 0;
    run_random_items(370);

    // receiver mostly stalling
    send_idle_pct  = 0;
    recv_stall_pct = 75;
    run_random_items(370);

    // both idling
    send_idle_pct  = 37;
    recv_stall_pct = 37;
    run_random_items(370);

    // drain
    in_valid       <= 1'b0;
    recv_stall_pct = 0;
    do @(posedge clk); while (results_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && results_pending == 0)
      $display("encoder_motor_position_stop_core regression: pass");
    else
      $display("encoder_motor_position_stop_core regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/emps_pkg.sv
hw/rtl/emps_in_stage.sv
hw/rtl/emps_ctrl.sv
hw/rtl/emps_out_stage.sv
hw/rtl/encoder_motor_position_stop_core.sv
tb/sv/motor_drive_checker.sv
tb/sv/tb_encoder_motor_position_stop_core.sv
